// ----- src/wss_pkg.sv -----
`timescale 1ns / 1ps

package wss_pkg;

   // Field widths fixed by the beat format
   localparam int DATA_W = 32;
   localparam int LEN_W  = 11;

   // Request action codes
   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic [LEN_W-1:0]         length_type;

endpackage

// ----- src/windowed_sample_statistics.sv -----
`timescale 1ns / 1ps

// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+-------------------------------
// request   | req_action, req_sample_value, req_window_length | start high, busy low at edge
// response  | rsp_latest_value, rsp_mean_value,               | rsp_valid high for one cycle,
//           | rsp_minimum_value, rsp_maximum_value,           | taken at the edge ending it
//           | rsp_stored_count                                |
//
// An add beat never raises busy. A query on an empty ring answers in the
// next cycle without raising busy. Any other query walks its n newest samples through the
// single ring read port (one sample a cycle), then runs a restoring divider one quotient bit
// a cycle over SW = 32 + clog2(DEPTH + 1) bits; busy stays high through the walk, drain,
// prep and divide states and falls in the cycle that shows the response. Reset (synchronous,
// active high) empties the ring. The receiver cannot stall; each response is shown exactly once.

module windowed_sample_statistics #(
   parameter int DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  wss_pkg::sample_type req_sample_value,
   input  wss_pkg::length_type req_window_length,
   output logic                rsp_valid,
   output wss_pkg::sample_type rsp_latest_value,
   output wss_pkg::sample_type rsp_mean_value,
   output wss_pkg::sample_type rsp_minimum_value,
   output wss_pkg::sample_type rsp_maximum_value,
   output wss_pkg::length_type rsp_stored_count
);

   localparam int DW  = wss_pkg::DATA_W;
   localparam int LNW = wss_pkg::LEN_W;
   localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // ring position
   localparam int CW  = $clog2(DEPTH + 1);                  // sample count
   localparam int LW  = (CW > LNW) ? CW : LNW;              // window compare
   localparam int SW  = DW + CW;                            // running sum
   localparam int STW = $clog2(SW + 1);                     // divider step count

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;   // wait for a request beat
   localparam logic [2:0] ST_WALK  = 3'd1;   // issue one ring read per cycle, newest first
   localparam logic [2:0] ST_DRAIN = 3'd2;   // fold in the last read sample
   localparam logic [2:0] ST_PREP  = 3'd3;   // take the sum magnitude into the divider
   localparam logic [2:0] ST_DIV   = 3'd4;   // one quotient bit per cycle

   // Sample ring
   logic [DW-1:0]       ring [DEPTH];
   logic [DW-1:0]       rd_data_ff;

   logic [2:0]          state_ff, state_in;
   logic [PW-1:0]       wr_pos_ff, wr_pos_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [PW-1:0]       rd_pos_ff, rd_pos_in;
   logic [CW-1:0]       left_ff, left_in;
   logic [CW-1:0]       n_ff, n_in;
   logic                data_vld_ff, data_vld_in;
   logic                first_ff, first_in;
   logic [SW-1:0]       sum_ff, sum_in;
   logic [DW-1:0]       min_ff, min_in;
   logic [DW-1:0]       max_ff, max_in;
   logic [DW-1:0]       latest_ff, latest_in;
   logic                neg_ff, neg_in;
   logic [SW-1:0]       quo_ff, quo_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [STW-1:0]      step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]       rsp_latest_ff, rsp_latest_in;
   logic [DW-1:0]       rsp_mean_ff, rsp_mean_in;
   logic [DW-1:0]       rsp_min_ff, rsp_min_in;
   logic [DW-1:0]       rsp_max_ff, rsp_max_in;
   logic [LNW-1:0]      rsp_count_ff, rsp_count_in;

   logic                accept;
   logic                is_add;
   logic                mem_we;
   logic [LW-1:0]       wlen_ext;
   logic [LW-1:0]       cnt_ext;
   logic [CW-1:0]       n_sel;
   logic [PW-1:0]       last_pos;
   logic [PW-1:0]       prev_rd;
   logic [SW-1:0]       v_ext;
   logic [SW-1:0]       sum_mag;
   logic [CW:0]         trial;
   logic [CW:0]         diff;
   logic                fits;
   logic [CW-1:0]       rem_next;
   logic [SW-1:0]       quo_next;
   logic [DW-1:0]       mean_signed;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start & ~busy;
   assign is_add  = (req_action == wss_pkg::ACT_ADD);
   assign mem_we  = accept & is_add;

   // Window length: zero or not below the count selects the whole history
   assign wlen_ext = LW'(req_window_length);
   assign cnt_ext  = LW'(count_ff);
   assign n_sel    = ((wlen_ext != '0) && (wlen_ext < cnt_ext)) ? CW'(wlen_ext) : count_ff;

   // Step back around the ring
   assign last_pos = (wr_pos_ff == '0) ? PW'(DEPTH - 1) : wr_pos_ff - PW'(1);
   assign prev_rd  = (rd_pos_ff == '0) ? PW'(DEPTH - 1) : rd_pos_ff - PW'(1);

   assign v_ext   = {{(SW-DW){rd_data_ff[DW-1]}}, rd_data_ff};
   assign sum_mag = sum_ff[SW-1] ? (~sum_ff + SW'(1)) : sum_ff;

   // Restoring divider step: shift in one dividend bit, subtract n when it fits
   assign trial    = {rem_ff, quo_ff[SW-1]};
   assign diff     = trial - {1'b0, n_ff};
   assign fits     = (trial >= {1'b0, n_ff});
   assign rem_next = fits ? diff[CW-1:0] : trial[CW-1:0];
   assign quo_next = {quo_ff[SW-2:0], fits};

   // Truncation toward zero: divide magnitudes, then restore the sign
   assign mean_signed = neg_ff ? (~quo_next[DW-1:0] + DW'(1)) : quo_next[DW-1:0];

   always_comb begin
      state_in      = state_ff;
      wr_pos_in     = wr_pos_ff;
      count_in      = count_ff;
      rd_pos_in     = rd_pos_ff;
      left_in       = left_ff;
      n_in          = n_ff;
      data_vld_in   = (state_ff == ST_WALK);
      first_in      = first_ff;
      sum_in        = sum_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      latest_in     = latest_ff;
      neg_in        = neg_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      rsp_valid_in  = 1'b0;
      rsp_latest_in = rsp_latest_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_count_in  = rsp_count_ff;

      // Fold the sample read last cycle into the running statistics
      if (data_vld_ff) begin
         first_in = 1'b0;
         if (first_ff) begin
            sum_in    = v_ext;
            min_in    = rd_data_ff;
            max_in    = rd_data_ff;
            latest_in = rd_data_ff;
         end else begin
            sum_in = sum_ff + v_ext;
            if ($signed(rd_data_ff) < $signed(min_ff)) begin
               min_in = rd_data_ff;
            end
            if ($signed(rd_data_ff) > $signed(max_ff)) begin
               max_in = rd_data_ff;
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_add) begin
                  // Overwrite the oldest slot once full; hold the count at DEPTH
                  wr_pos_in = (wr_pos_ff == PW'(DEPTH - 1)) ? '0 : wr_pos_ff + PW'(1);
                  if (count_ff != CW'(DEPTH)) begin
                     count_in = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  // Empty ring: every statistic reads zero
                  rsp_valid_in  = 1'b1;
                  rsp_latest_in = '0;
                  rsp_mean_in   = '0;
                  rsp_min_in    = '0;
                  rsp_max_in    = '0;
                  rsp_count_in  = '0;
               end else begin
                  n_in      = n_sel;
                  left_in   = n_sel;
                  rd_pos_in = last_pos;
                  first_in  = 1'b1;
                  state_in  = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            rd_pos_in = prev_rd;
            left_in   = left_ff - CW'(1);
            if (left_ff == CW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            neg_in   = sum_ff[SW-1];
            quo_in   = sum_mag;
            rem_in   = '0;
            step_in  = STW'(SW);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            quo_in  = quo_next;
            rem_in  = rem_next;
            step_in = step_ff - STW'(1);
            if (step_ff == STW'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_latest_in = latest_ff;
               rsp_mean_in   = mean_signed;
               rsp_min_in    = min_ff;
               rsp_max_in    = max_ff;
               rsp_count_in  = LNW'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring[wr_pos_ff] <= req_sample_value;
      end
      rd_data_ff <= ring[rd_pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_pos_ff    <= '0;
         count_ff     <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         count_ff     <= count_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff     <= rd_pos_in;
      left_ff       <= left_in;
      n_ff          <= n_in;
      first_ff      <= first_in;
      sum_ff        <= sum_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      latest_ff     <= latest_in;
      neg_ff        <= neg_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      rsp_latest_ff <= rsp_latest_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_latest_value  = rsp_latest_ff;
   assign rsp_mean_value    = rsp_mean_ff;
   assign rsp_minimum_value = rsp_min_ff;
   assign rsp_maximum_value = rsp_max_ff;
   assign rsp_stored_count  = rsp_count_ff;

endmodule

// ----- src/wss_checker.sv -----
`timescale 1ns / 1ps

module wss_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_action,
   input wss_pkg::sample_type req_sample_value,
   input wss_pkg::length_type req_window_length,
   input logic                rsp_valid,
   input wss_pkg::sample_type rsp_latest_value,
   input wss_pkg::sample_type rsp_mean_value,
   input wss_pkg::sample_type rsp_minimum_value,
   input wss_pkg::sample_type rsp_maximum_value,
   input wss_pkg::length_type rsp_stored_count
);

   // An add beat never produces a response
   a_add_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == wss_pkg::ACT_ADD) |=> !rsp_valid)
      else $error("response after an add beat");

   // A response beat is shown only with the sequencer back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // Empty ring reports all zero statistics
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stored_count == '0) |->
         (rsp_latest_value == '0 && rsp_mean_value == '0 &&
          rsp_minimum_value == '0 && rsp_maximum_value == '0))
      else $error("nonzero statistics for an empty ring");

   // Mean lies between minimum and maximum
   a_mean_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_minimum_value <= rsp_mean_value &&
                     rsp_mean_value <= rsp_maximum_value))
      else $error("mean outside minimum and maximum");

endmodule

bind windowed_sample_statistics wss_checker u_wss_checker (.*);

// ----- tb/wss_response_checker.sv -----
`timescale 1ns / 1ps

module wss_response_checker #(
   parameter int DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_action,
   input  wss_pkg::sample_type req_sample_value,
   input  wss_pkg::length_type req_window_length,
   input  logic                rsp_valid,
   input  wss_pkg::sample_type rsp_latest_value,
   input  wss_pkg::sample_type rsp_mean_value,
   input  wss_pkg::sample_type rsp_minimum_value,
   input  wss_pkg::sample_type rsp_maximum_value,
   input  wss_pkg::length_type rsp_stored_count,
   output int                  fail_count,
   output int                  pending_count
);
   import wss_pkg::*;

   typedef struct {
      sample_type latest;
      sample_type mean;
      sample_type lowest;
      sample_type highest;
      length_type stored;
   } summary_type;

   sample_type  ring [DEPTH];
   int unsigned head;
   int unsigned fill_level;
   summary_type awaited_summaries [$];
   int          mismatches = 0;

   task automatic report_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   // Walk back from the newest sample over the window; empty ring gives all zeros.
   function automatic summary_type summarize_window(input length_type span);
      summary_type s;
      int unsigned n;
      int unsigned pos;
      int unsigned k;
      longint      total;
      sample_type  v;
      s.latest  = '0;
      s.mean    = '0;
      s.lowest  = '0;
      s.highest = '0;
      s.stored  = length_type'(fill_level);
      if (fill_level == 0)
         return s;
      n = fill_level;
      if (span != 0 && span < n)
         n = span;
      pos = (head == 0) ? DEPTH - 1 : head - 1;
      s.latest  = ring[pos];
      s.lowest  = ring[pos];
      s.highest = ring[pos];
      total = 0;
      for (k = 0; k < n; k++) begin
         v = ring[pos];
         total += v;
         if (v < s.lowest)
            s.lowest = v;
         if (v > s.highest)
            s.highest = v;
         pos = (pos == 0) ? DEPTH - 1 : pos - 1;
      end
      s.mean = sample_type'(total / longint'(n));
      return s;
   endfunction

   // Check first: a response at this edge always belongs to an older query.
   always @(posedge clock) begin
      summary_type due;
      if (reset) begin
         head = 0;
         fill_level = 0;
         awaited_summaries.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_summaries.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual latest %0d count %0d",
                        $time, rsp_latest_value, rsp_stored_count);
               mismatches++;
            end else begin
               due = awaited_summaries.pop_front();
               if (rsp_latest_value !== due.latest)
                  report_field("latest_value", due.latest, rsp_latest_value);
               if (rsp_mean_value !== due.mean)
                  report_field("mean_value", due.mean, rsp_mean_value);
               if (rsp_minimum_value !== due.lowest)
                  report_field("minimum_value", due.lowest, rsp_minimum_value);
               if (rsp_maximum_value !== due.highest)
                  report_field("maximum_value", due.highest, rsp_maximum_value);
               if (rsp_stored_count !== due.stored)
                  report_field("stored_count", due.stored, rsp_stored_count);
            end
         end
         if (start && !busy) begin
            if (req_action == ACT_ADD) begin
               ring[head] = req_sample_value;
               head = (head == DEPTH - 1) ? 0 : head + 1;
               if (fill_level < DEPTH)
                  fill_level++;
            end else begin
               awaited_summaries.push_back(summarize_window(req_window_length));
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= awaited_summaries.size();
   end

endmodule

// ----- tb/tb_windowed_sample_statistics.sv -----
`timescale 1ns / 1ps

module tb_windowed_sample_statistics;
   import wss_pkg::*;

   localparam int DEPTH = 1024;
   // A full-window query keeps busy high longest, and the sender may add a short gap on top.
   // Allow several times that span before calling the run hung.
   localparam int STALL_LIMIT  = 6 * (DEPTH + 64);
   // Quiet time after the last response: long enough for any stray response to show.
   localparam int DRAIN_CYCLES = DEPTH + 64;
   localparam int PHASE_BEATS  = 142;

   localparam sample_type SAMPLE_MAX = {1'b0, {31{1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, 31'b0};

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_action;
   sample_type req_sample_value;
   length_type req_window_length;
   logic       rsp_valid;
   sample_type rsp_latest_value;
   sample_type rsp_mean_value;
   sample_type rsp_minimum_value;
   sample_type rsp_maximum_value;
   length_type rsp_stored_count;

   int          fail_count;
   int          pending_count;
   int          stall_cycles = 0;
   int unsigned samples_sent = 0;

   always #5 clock = ~clock;

   windowed_sample_statistics #(
      .DEPTH(DEPTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_sample_value (req_sample_value),
      .req_window_length(req_window_length),
      .rsp_valid        (rsp_valid),
      .rsp_latest_value (rsp_latest_value),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_minimum_value(rsp_minimum_value),
      .rsp_maximum_value(rsp_maximum_value),
      .rsp_stored_count (rsp_stored_count)
   );

   wss_response_checker #(
      .DEPTH(DEPTH)
   ) checker_inst (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_sample_value (req_sample_value),
      .req_window_length(req_window_length),
      .rsp_valid        (rsp_valid),
      .rsp_latest_value (rsp_latest_value),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_minimum_value(rsp_minimum_value),
      .rsp_maximum_value(rsp_maximum_value),
      .rsp_stored_count (rsp_stored_count),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // Watchdog: count edges at which neither a request nor a response beat moves.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Mix of extremes, small values around zero (where rounding of the mean shows) and
   // full-range values so every bit of the sample toggles.
   function automatic sample_type pick_sample();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3)
         return SAMPLE_MAX;
      if (roll < 6)
         return SAMPLE_MIN;
      if (roll < 8)
         return '1;
      if (roll < 10)
         return '0;
      if (roll < 55)
         return sample_type'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      return sample_type'($urandom);
   endfunction

   // Call right after a falling edge. Optionally idle first (start low, junk on the
   // fields), then hold the beat until an edge finds busy low, and return on the next
   // falling edge. Start is never lowered and raised in the same step.
   task automatic send_beat(input int idle_pct, input logic act, input sample_type value,
                            input length_type span);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start             <= 1'b0;
         req_action        <= 1'($urandom);
         req_sample_value  <= sample_type'($urandom);
         req_window_length <= length_type'($urandom);
         repeat (gap) @(negedge clock);
      end
      start             <= 1'b1;
      req_action        <= act;
      req_sample_value  <= value;
      req_window_length <= span;
      do
         @(posedge clock);
      while (busy);
      if (act == ACT_ADD)
         samples_sent++;
      @(negedge clock);
   endtask

   initial begin
      int          phase;
      int          idle_pct;
      int          k;
      int unsigned roll;
      int unsigned held;
      int unsigned span;

      reset             = 1'b1;
      start             = 1'b0;
      req_action        = ACT_ADD;
      req_sample_value  = '0;
      req_window_length = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty ring: every statistic is zero, with both the default and the widest window.
      send_beat(25, ACT_QUERY, SAMPLE_MAX, 11'd0);
      send_beat(25, ACT_QUERY, SAMPLE_MIN, 11'd2047);
      // Single sample, then the two extremes side by side.
      send_beat(25, ACT_ADD, SAMPLE_MAX, 11'd0);
      send_beat(25, ACT_QUERY, '0, 11'd0);
      send_beat(25, ACT_ADD, SAMPLE_MIN, 11'd2047);
      send_beat(25, ACT_QUERY, '0, 11'd1);
      send_beat(25, ACT_QUERY, '0, 11'd2);
      send_beat(25, ACT_QUERY, '0, 11'd0);
      // Signs mixed in the window; window equal to and beyond the stored count.
      send_beat(25, ACT_ADD, '1, 11'd0);
      send_beat(25, ACT_ADD, 32'sd1, 11'd0);
      send_beat(25, ACT_QUERY, '0, 11'd3);
      send_beat(25, ACT_QUERY, '0, 11'd4);
      send_beat(25, ACT_QUERY, '0, 11'd2047);
      send_beat(25, ACT_QUERY, '0, 11'd1024);
      // Negative half-way mean: truncate toward zero, not toward minus infinity.
      send_beat(25, ACT_ADD, -32'sd3, 11'd0);
      send_beat(25, ACT_ADD, -32'sd4, 11'd0);
      send_beat(25, ACT_QUERY, '0, 11'd2);
      send_beat(25, ACT_ADD, 32'sd7, 11'd0);
      send_beat(25, ACT_QUERY, '0, 11'd2);
      // Large negative sum over two minimum samples.
      send_beat(25, ACT_ADD, SAMPLE_MIN, 11'd0);
      send_beat(25, ACT_ADD, SAMPLE_MIN, 11'd0);
      send_beat(25, ACT_QUERY, '0, 11'd2);
      send_beat(25, ACT_QUERY, '0, 11'd0);

      // Random part in three phases of mixed adds and queries, each with its own idle rate.
      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 25 : (phase == 1) ? 49 : 0;
         for (k = 0; k < PHASE_BEATS; k++) begin
            held = (samples_sent < DEPTH) ? samples_sent : DEPTH;
            roll = $urandom_range(99);
            if (roll < 55) begin
               send_beat(idle_pct, ACT_ADD, pick_sample(), length_type'($urandom));
            end else begin
               // Mostly short windows; the costly full-history ones stay a minority.
               roll = $urandom_range(99);
               if (roll < 40)
                  span = $urandom_range(1, 16);
               else if (roll < 55)
                  span = 0;
               else if (roll < 70)
                  span = $urandom_range(17, 200);
               else if (roll < 85)
                  span = held + $urandom_range(0, 2) - 1;
               else if (roll < 93)
                  span = $urandom_range(1024, 2047);
               else
                  span = $urandom_range(990, 1024);
               send_beat(idle_pct, ACT_QUERY, pick_sample(), length_type'(span));
            end
         end
      end

      start <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
